@@ hw/rtl/msfe_pkg.sv @@
// Shared types, constants and codes for the marker scan field extractor.
package msfe_pkg;

    localparam int TAG_LENGTH_DEF = 10;
    localparam int SKIP_BYTES_DEF = 4;
    localparam int WORD_BYTES_DEF = 8;
    localparam int TAG_MAX        = 16;
    localparam int OUT_DEPTH      = 4;

    localparam logic [7:0] TAG_TEXT [TAG_MAX] = '{
        8'h57, 8'h61, 8'h72, 8'h70, 8'h4D, 8'h61, 8'h72, 8'h6B,
        8'h65, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_SKIP_COUNT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RECORD_LIMIT = 2'd1;

    localparam logic [1:0] SKIP_COUNT_RESET   = 2'd1;
    localparam logic [1:0] RECORD_LIMIT_RESET = 2'd2;
    localparam logic [1:0] RECORDS_MAX        = 2'd3;

    localparam logic [1:0] KIND_RECORD    = 2'd0;
    localparam logic [1:0] KIND_FOUND     = 2'd1;
    localparam logic [1:0] KIND_NOT_FOUND = 2'd2;

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_SKIP   = 2'd1,
        PH_POS    = 2'd2,
        PH_BEAT   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] position_bits;
        logic [63:0] beat_bits;
        logic [1:0]  record_index;
        logic        last_result;
    } t_out_item;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

endpackage

@@ hw/rtl/msfe_cell.sv @@
// One byte cell of the scan chain: holds a byte, passes it on, checks the arriving byte.
module msfe_cell #(
    parameter bit         CHECK    = 1'b0,
    parameter logic [7:0] TAG_BYTE = 8'h00
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  msfe_pkg::t_cell_ctrl i_ctrl,
    input  logic [7:0]           i_byte,
    output logic [7:0]           o_byte,
    output logic                 o_match
);
    import msfe_pkg::*;

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_byte <= 8'h00;
        end else if (i_ctrl.shift) begin
            r_byte <= i_byte;
        end
    end

    // Cells below the tag window always report a match.
    assign o_match = !CHECK || (i_byte == TAG_BYTE);
    assign o_byte  = r_byte;

endmodule

@@ hw/rtl/msfe_chain.sv @@
// Row of byte cells: tag window compare at the newest end, word bytes read from the chain.
module msfe_chain #(
    parameter int TAG_LENGTH = msfe_pkg::TAG_LENGTH_DEF,
    parameter int WORD_BYTES = msfe_pkg::WORD_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  msfe_pkg::t_cell_ctrl i_ctrl,
    input  logic [7:0]           i_byte,
    output logic                 o_hit,
    output logic [63:0]          o_position_bits,
    output logic [63:0]          o_beat_bits
);
    import msfe_pkg::*;

    localparam int NCELLS = (TAG_LENGTH > 2 * WORD_BYTES) ? TAG_LENGTH : 2 * WORD_BYTES;
    localparam int WIN_BASE  = NCELLS - TAG_LENGTH;
    localparam int WORD_BASE = NCELLS - 2 * WORD_BYTES;

    logic [7:0]        cell_in [NCELLS];
    logic [7:0]        cell_q  [NCELLS];
    logic [NCELLS-1:0] cell_match;

    // The newest byte enters at the top cell; each cell takes its upper neighbor's byte.
    for (genvar k = 0; k < NCELLS; k++) begin : g_cell
        if (k == NCELLS - 1) begin : g_top
            assign cell_in[k] = i_byte;
        end else begin : g_mid
            assign cell_in[k] = cell_q[k+1];
        end

        if (k >= WIN_BASE) begin : g_win
            msfe_cell #(
                .CHECK    (1'b1),
                .TAG_BYTE (TAG_TEXT[k-WIN_BASE])
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (i_ctrl),
                .i_byte  (cell_in[k]),
                .o_byte  (cell_q[k]),
                .o_match (cell_match[k])
            );
        end else begin : g_data
            msfe_cell #(
                .CHECK    (1'b0),
                .TAG_BYTE (8'h00)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (i_ctrl),
                .i_byte  (cell_in[k]),
                .o_byte  (cell_q[k]),
                .o_match (cell_match[k])
            );
        end
    end

    assign o_hit = &cell_match;

    // After the final beat byte arrives, sequence byte s is on the input of cell WORD_BASE + s.
    for (genvar j = 0; j < 8; j++) begin : g_word
        if (j < WORD_BYTES) begin : g_used
            assign o_position_bits[8*j +: 8] = cell_in[WORD_BASE + j];
            assign o_beat_bits[8*j +: 8]     = cell_in[WORD_BASE + WORD_BYTES + j];
        end else begin : g_zero
            assign o_position_bits[8*j +: 8] = 8'h00;
            assign o_beat_bits[8*j +: 8]     = 8'h00;
        end
    end

endmodule

@@ hw/rtl/marker_scan_field_extractor_unit.sv @@
// Top level of the marker scan field extractor: sequencing, output queue and configuration.
//
// The block takes one file byte per clock. Bytes shift through a row of byte cells whose
// newest TAG_LENGTH cells compare against the tag in parallel, so a match is seen on the
// byte that completes it. After a match that is not discarded, SKIP_BYTES bytes are
// passed over and the next 2*WORD_BYTES bytes, still held in the same cells, form the
// position and beat words. A record is queued when its last byte is accepted, and an
// end-of-stream status goes in behind it (or stands alone) for the same byte. Results
// go into a four-entry queue; an input byte is taken whenever the queue
// has two free entries, so the sustained rate is one byte per clock as long as the
// consumer drains results, each byte causing at most two. Configuration writes are taken
// at once in any cycle.
module marker_scan_field_extractor_unit #(
    parameter int TAG_LENGTH = msfe_pkg::TAG_LENGTH_DEF,
    parameter int SKIP_BYTES = msfe_pkg::SKIP_BYTES_DEF,
    parameter int WORD_BYTES = msfe_pkg::WORD_BYTES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  msfe_pkg::t_in_item                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output msfe_pkg::t_out_item                  o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [msfe_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [msfe_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import msfe_pkg::*;

    localparam int CNT_MAX = (SKIP_BYTES > WORD_BYTES) ? SKIP_BYTES : WORD_BYTES;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam int FR_W    = $clog2(TAG_LENGTH + 1);
    localparam int PTR_W   = $clog2(OUT_DEPTH);
    localparam int CNT_Q_W = $clog2(OUT_DEPTH + 1);

    localparam logic [CNT_W-1:0]   SKIP_END  = CNT_W'(SKIP_BYTES);
    localparam logic [CNT_W-1:0]   WORD_END  = CNT_W'(WORD_BYTES);
    localparam logic [FR_W-1:0]    FRESH_END = FR_W'(TAG_LENGTH);
    localparam logic [CNT_Q_W-1:0] Q_DEPTH   = CNT_Q_W'(OUT_DEPTH);
    localparam logic [CNT_Q_W-1:0] Q_ROOM    = CNT_Q_W'(OUT_DEPTH - 2);

    // Configuration registers.
    logic [1:0] r_skip_count;
    logic [1:0] r_record_limit;

    // Stream state.
    t_phase           r_phase,   n_phase;
    logic [CNT_W-1:0] r_cnt,     n_cnt;
    logic [FR_W-1:0]  r_fresh,   n_fresh;
    logic [1:0]       r_matches, n_matches;
    logic [1:0]       r_records, n_records;

    // Output queue.
    t_out_item          r_fifo [OUT_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_Q_W-1:0] r_count;

    logic        accept;
    logic        active;
    logic        eos;
    logic        chain_hit;
    logic        hit;
    logic [63:0] position_bits;
    logic [63:0] beat_bits;
    logic [FR_W-1:0]  fresh_inc;
    logic [CNT_W-1:0] cnt_inc;
    logic        skip_done;
    logic        word_done;
    logic [1:0]  records_inc;
    logic [1:0]  records_after;
    logic        rec_emit;
    t_cell_ctrl  cell_ctrl;
    t_out_item   rec_item;
    t_out_item   status_item;
    t_out_item   first_item;
    logic [1:0]  push_n;
    logic        pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_count <= Q_ROOM);
    assign accept      = i_in_valid && o_in_ready;
    assign eos         = i_in_data.end_of_stream;
    assign active      = (r_records < r_record_limit);

    assign fresh_inc   = (r_fresh < FRESH_END) ? r_fresh + 1'b1 : r_fresh;
    assign hit         = chain_hit && (fresh_inc == FRESH_END);
    assign cnt_inc     = r_cnt + 1'b1;
    assign skip_done   = (cnt_inc >= SKIP_END);
    assign word_done   = (cnt_inc >= WORD_END);
    assign records_inc = (r_records == RECORDS_MAX) ? r_records : r_records + 2'd1;

    msfe_chain #(
        .TAG_LENGTH (TAG_LENGTH),
        .WORD_BYTES (WORD_BYTES)
    ) u_chain (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (cell_ctrl),
        .i_byte          (i_in_data.data_byte),
        .o_hit           (chain_hit),
        .o_position_bits (position_bits),
        .o_beat_bits     (beat_bits)
    );

    // Next-state logic of the phase sequencer and its counters.
    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_fresh   = r_fresh;
        n_matches = r_matches;
        n_records = r_records;
        if (accept && active) begin
            unique case (r_phase)
                PH_SEARCH: begin
                    n_fresh = fresh_inc;
                    if (hit) begin
                        n_fresh = '0;
                        if (r_matches < r_skip_count) begin
                            n_matches = r_matches + 2'd1;
                        end else if (SKIP_BYTES == 0) begin
                            n_phase = PH_POS;
                            n_cnt   = '0;
                        end else begin
                            n_phase = PH_SKIP;
                            n_cnt   = '0;
                        end
                    end
                end
                PH_SKIP: begin
                    if (skip_done) begin
                        n_phase = PH_POS;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
                PH_POS: begin
                    if (word_done) begin
                        n_phase = PH_BEAT;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
                PH_BEAT: begin
                    if (word_done) begin
                        n_phase   = PH_SEARCH;
                        n_cnt     = '0;
                        n_fresh   = '0;
                        n_records = records_inc;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
                default: begin
                    n_phase = PH_SEARCH;
                end
            endcase
        end
        // The end of a file returns all stream state to its reset value.
        if (accept && eos) begin
            n_phase   = PH_SEARCH;
            n_cnt     = '0;
            n_fresh   = '0;
            n_matches = '0;
            n_records = '0;
        end
    end

    // Sequencer outputs: cell control and record emission.
    always_comb begin
        cell_ctrl.shift = accept && active;
        cell_ctrl.clear = accept && eos;
        rec_emit        = 1'b0;
        unique case (r_phase)
            PH_BEAT: rec_emit = accept && active && word_done;
            default: rec_emit = 1'b0;
        endcase
    end

    assign records_after = rec_emit ? records_inc : r_records;

    always_comb begin
        rec_item.kind          = KIND_RECORD;
        rec_item.position_bits = position_bits;
        rec_item.beat_bits     = beat_bits;
        rec_item.record_index  = r_records;
        rec_item.last_result   = !eos;

        status_item.kind          = (records_after >= r_record_limit) ? KIND_FOUND
                                                                      : KIND_NOT_FOUND;
        status_item.position_bits = '0;
        status_item.beat_bits     = '0;
        status_item.record_index  = '0;
        status_item.last_result   = 1'b1;

        first_item = rec_emit ? rec_item : status_item;
        push_n     = accept ? {1'b0, rec_emit} + {1'b0, eos} : 2'd0;
    end

    assign pop         = o_out_valid && i_out_ready;
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_fifo[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SEARCH;
            r_cnt     <= '0;
            r_fresh   <= '0;
            r_matches <= '0;
            r_records <= '0;
        end else begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_fresh   <= n_fresh;
            r_matches <= n_matches;
            r_records <= n_records;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_count   <= SKIP_COUNT_RESET;
            r_record_limit <= RECORD_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SKIP_COUNT:   r_skip_count   <= i_cfg_data;
                CFG_RECORD_LIMIT: r_record_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(push_n);
            r_rd_ptr <= r_rd_ptr + PTR_W'(pop);
            r_count  <= r_count + CNT_Q_W'(push_n) - CNT_Q_W'(pop);
        end
    end

    // When a byte completes a record and ends the file, the status goes in behind it.
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_fifo[r_wr_ptr] <= first_item;
        end
        if (push_n == 2'd2) begin
            r_fifo[r_wr_ptr + PTR_W'(1)] <= status_item;
        end
    end

    a_queue_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_DEPTH)
        else $error("output queue holds more transactions than its depth");

    a_eos_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && eos) |=> (r_phase == PH_SEARCH && r_records == '0
                             && r_matches == '0 && r_fresh == '0))
        else $error("stream state not cleared after end of stream");

    a_record_capture : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rec_emit |-> (r_records < r_record_limit && o_in_ready)
                     ##1 (r_count != '0))
        else $error("record emitted outside capture or not queued");

endmodule

@@ tb/tb_marker_scan_field_extractor_unit.sv @@
// Self-checking testbench for the marker scan field extractor unit.
`timescale 1ns / 100ps

module tb_marker_scan_field_extractor_unit;
    import msfe_pkg::*;

    localparam int TAG_LEN     = TAG_LENGTH_DEF;
    localparam int WATCH_LIMIT = 3000;
    localparam int SETTLE      = 8;
    localparam int ITEM_TARGET = 1150;
    localparam int PHASE_ITEMS = 140;
    localparam int PHASE_FILES = 30;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_PRINTS  = 30;

    // Register index with no register behind it; a write there must change nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd2;
    // Marks a directed row whose status kind is left to the predictor.
    localparam logic [1:0] WANT_PREDICT = 2'd3;

    localparam logic [1:0] SKIP_PLAN  [8] = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd0, 2'd3, 2'd2, 2'd1};
    localparam logic [1:0] LIMIT_PLAN [8] = '{2'd1, 2'd3, 2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd1};

    typedef enum logic {ROW_BYTE, ROW_CFG} t_row_op;

    typedef struct packed {
        t_row_op                op;
        logic [7:0]             data;
        logic                   eos;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        logic [1:0]             want;
    } t_dir_row;

    localparam int N_DIR = 41;

    // op, byte, end, register, value, typed status kind
    t_dir_row dir_rows [N_DIR] = '{
        '{ROW_BYTE, 8'h00, 1'b1, CFG_SKIP_COUNT,   2'd0, KIND_NOT_FOUND},
        '{ROW_BYTE, 8'hFF, 1'b1, CFG_SKIP_COUNT,   2'd0, KIND_NOT_FOUND},
        '{ROW_CFG,  8'h00, 1'b0, CFG_SKIP_COUNT,   2'd0, WANT_PREDICT},
        '{ROW_CFG,  8'h00, 1'b0, CFG_RECORD_LIMIT, 2'd0, WANT_PREDICT},
        '{ROW_BYTE, 8'hA5, 1'b1, CFG_SKIP_COUNT,   2'd0, KIND_FOUND},
        '{ROW_CFG,  8'h00, 1'b0, CFG_RECORD_LIMIT, 2'd1, WANT_PREDICT},
        // The tag itself, "WarpMarker".
        '{ROW_BYTE, 8'h57, 1'b0, CFG_SKIP_COUNT,   2'd0, WANT_PREDICT},
        '{ROW_BYTE, 8'h61, 1'b0, CFG_SKIP_COUNT,   2'd0, WANT_PREDICT},
        '{ROW_BYTE, 8'h72, 1'b0, CFG_SKIP_COUNT,   2'd0, WANT_PREDICT},
        '{ROW_BYTE, 8'h70, 1'b0, CFG_SKIP_COUNT,   2'd0, WANT_PREDICT},
        '{ROW_BYTE, 8'h4D, 1'b0, CFG_SKIP_COUNT,   2'd0, WANT_PREDICT},
        '{ROW_BYTE, 8'h61, 1'b0, CFG_SKIP_COUNT,   2'd0, WANT_PREDICT},
        '{ROW_BYTE, 8'h72, 1'b0, CFG_SKIP_COUNT,   2'd0, WANT_PREDICT},
        '{ROW_BYTE, 8'h6B, 1'b0, CFG_SKIP_COUNT,   2'd0, WANT_PREDICT},
        '{ROW_BYTE, 8'h65, 1'b0, CFG_SKIP_COUNT,   2'd0, WANT_PREDICT},
        '{ROW_BYTE, 8'h72, 1'b0, CFG_SKIP_COUNT,   2'd0, WANT_PREDICT},
        // Skipped bytes.
        '{ROW_BYTE, 8'h00, 1'b0, CFG_SKIP_COUNT,   2'd0, WANT_PREDICT},
        '{ROW_BYTE, 8'hFF, 1'b0, CFG_SKIP_COUNT,   2'd0, WANT_PREDICT},
        '{ROW_BYTE, 8'h00, 1'b0, CFG_SKIP_COUNT,   2'd0, WANT_PREDICT},
        '{ROW_BYTE, 8'hFF, 1'b0, CFG_SKIP_COUNT,   2'd0, WANT_PREDICT},
        // Position word of all ones.
        '{ROW_BYTE, 8'hFF, 1'b0, CFG_SKIP_COUNT,   2'd0, WANT_PREDICT},
        '{ROW_BYTE, 8'hFF, 1'b0, CFG_SKIP_COUNT,   2'd0, WANT_PREDICT},
        '{ROW_BYTE, 8'hFF, 1'b0, CFG_SKIP_COUNT,   2'd0, WANT_PREDICT},
        '{ROW_BYTE, 8'hFF, 1'b0, CFG_SKIP_COUNT,   2'd0, WANT_PREDICT},
        '{ROW_BYTE, 8'hFF, 1'b0, CFG_SKIP_COUNT,   2'd0, WANT_PREDICT},
        '{ROW_BYTE, 8'hFF, 1'b0, CFG_SKIP_COUNT,   2'd0, WANT_PREDICT},
        '{ROW_BYTE, 8'hFF, 1'b0, CFG_SKIP_COUNT,   2'd0, WANT_PREDICT},
        '{ROW_BYTE, 8'hFF, 1'b0, CFG_SKIP_COUNT,   2'd0, WANT_PREDICT},
        // Beat word with only the top bit set; its last byte also ends the file.
        '{ROW_BYTE, 8'h00, 1'b0, CFG_SKIP_COUNT,   2'd0, WANT_PREDICT},
        '{ROW_BYTE, 8'h00, 1'b0, CFG_SKIP_COUNT,   2'd0, WANT_PREDICT},
        '{ROW_BYTE, 8'h00, 1'b0, CFG_SKIP_COUNT,   2'd0, WANT_PREDICT},
        '{ROW_BYTE, 8'h00, 1'b0, CFG_SKIP_COUNT,   2'd0, WANT_PREDICT},
        '{ROW_BYTE, 8'h00, 1'b0, CFG_SKIP_COUNT,   2'd0, WANT_PREDICT},
        '{ROW_BYTE, 8'h00, 1'b0, CFG_SKIP_COUNT,   2'd0, WANT_PREDICT},
        '{ROW_BYTE, 8'h00, 1'b0, CFG_SKIP_COUNT,   2'd0, WANT_PREDICT},
        '{ROW_BYTE, 8'h80, 1'b1, CFG_SKIP_COUNT,   2'd0, KIND_FOUND},
        '{ROW_CFG,  8'h00, 1'b0, CFG_SKIP_COUNT,   2'd3, WANT_PREDICT},
        '{ROW_CFG,  8'h00, 1'b0, CFG_RECORD_LIMIT, 2'd3, WANT_PREDICT},
        '{ROW_BYTE, 8'h5A, 1'b1, CFG_SKIP_COUNT,   2'd0, KIND_NOT_FOUND},
        '{ROW_CFG,  8'h00, 1'b0, CFG_SPARE,        2'd3, WANT_PREDICT},
        '{ROW_BYTE, 8'h00, 1'b1, CFG_SKIP_COUNT,   2'd0, KIND_NOT_FOUND}
    };

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    t_in_item               in_data   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    t_out_item              out_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Predictor state: register copies and the scan of the current file.
    logic [CFG_DATA_W-1:0] cur_skip_count;
    logic [CFG_DATA_W-1:0] cur_record_limit;
    logic [7:0]            scan_win [TAG_LEN];
    int                    fresh_bytes;
    int                    field_bytes;
    int                    discarded;
    int                    captured;
    t_phase                scan_phase;
    logic [63:0]           pos_acc;
    logic [63:0]           beat_acc;
    t_out_item             due_results [$];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_len     = 0;
    int stuck_cycles = 0;
    int err_count    = 0;
    int byte_count   = 0;
    int file_count   = 0;
    int record_count = 0;
    int status_count = 0;
    int cfg_writes   = 0;

    marker_scan_field_extractor_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want_v);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("%0t ns: mismatch in %s: got %h, expected %h", $time, what, got, want_v);
    endtask

    task automatic clear_scan();
        foreach (scan_win[i]) scan_win[i] = 8'h00;
        fresh_bytes = 0;
        field_bytes = 0;
        discarded   = 0;
        captured    = 0;
        scan_phase  = PH_SEARCH;
        pos_acc     = '0;
        beat_acc    = '0;
    endtask

    // Advances the scan by one accepted byte and queues the results it causes.
    task automatic scan_byte(input logic [7:0] b, input logic eos, input logic [1:0] want);
        t_out_item caused [$];
        t_out_item r;
        logic      hit;
        byte_count++;
        if (captured < int'(cur_record_limit)) begin
            case (scan_phase)
                PH_SEARCH: begin
                    for (int i = 0; i < TAG_LEN - 1; i++) scan_win[i] = scan_win[i + 1];
                    scan_win[TAG_LEN - 1] = b;
                    if (fresh_bytes < TAG_LEN) fresh_bytes++;
                    // A window only counts once it holds bytes all seen since the last search start.
                    hit = (fresh_bytes >= TAG_LEN);
                    for (int i = 0; i < TAG_LEN; i++)
                        if (scan_win[i] != TAG_TEXT[i]) hit = 1'b0;
                    if (hit) begin
                        fresh_bytes = 0;
                        if (discarded < int'(cur_skip_count)) begin
                            discarded++;
                        end else begin
                            scan_phase  = PH_SKIP;
                            field_bytes = 0;
                        end
                    end
                end
                PH_SKIP: begin
                    field_bytes++;
                    if (field_bytes >= SKIP_BYTES_DEF) begin
                        scan_phase  = PH_POS;
                        field_bytes = 0;
                        pos_acc     = '0;
                        beat_acc    = '0;
                    end
                end
                PH_POS: begin
                    pos_acc[8 * field_bytes +: 8] = b;
                    field_bytes++;
                    if (field_bytes >= WORD_BYTES_DEF) begin
                        scan_phase  = PH_BEAT;
                        field_bytes = 0;
                    end
                end
                default: begin
                    beat_acc[8 * field_bytes +: 8] = b;
                    field_bytes++;
                    if (field_bytes >= WORD_BYTES_DEF) begin
                        r               = '0;
                        r.kind          = KIND_RECORD;
                        r.position_bits = pos_acc;
                        r.beat_bits     = beat_acc;
                        r.record_index  = 2'(captured);
                        caused.push_back(r);
                        record_count++;
                        if (captured < int'(RECORDS_MAX)) captured++;
                        scan_phase  = PH_SEARCH;
                        field_bytes = 0;
                        fresh_bytes = 0;
                    end
                end
            endcase
        end
        if (eos) begin
            r      = '0;
            r.kind = (captured >= int'(cur_record_limit)) ? KIND_FOUND : KIND_NOT_FOUND;
            if (want != WANT_PREDICT) r.kind = want;
            caused.push_back(r);
            status_count++;
            clear_scan();
        end
        if (caused.size() > 0) caused[caused.size() - 1].last_result = 1'b1;
        foreach (caused[k]) due_results.push_back(caused[k]);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eos, input logic [1:0] want);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{data_byte: b, end_of_stream: eos};
        do @(posedge clk); while (!in_ready);
        scan_byte(b, eos, want);
    endtask

    // Registers change only with the block drained and quiet.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        in_valid <= 1'b0;
        while (due_results.size() > 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_SKIP_COUNT)
            cur_skip_count = val;
        else if (idx == CFG_RECORD_LIMIT)
            cur_record_limit = val;
        cfg_writes++;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return TAG_TEXT[$urandom_range(TAG_LEN - 1)];
            default: return 8'($urandom);
        endcase
    endfunction

    // One file: mostly tags with their fields among junk, sometimes cut short or pure noise.
    task automatic send_file();
        logic [7:0] bytes_q [$];
        int         n_tags;
        int         plen;
        int         bad_at;
        int         cut_len;
        int         style;
        style = $urandom_range(9);
        if (style == 0) begin
            repeat ($urandom_range(1, 24)) bytes_q.push_back(pick_byte());
        end else begin
            n_tags = $urandom_range(int'(cur_skip_count) + int'(cur_record_limit) + 1);
            for (int t = 0; t < n_tags; t++) begin
                repeat ($urandom_range(6)) bytes_q.push_back(pick_byte());
                if ($urandom_range(4) == 0) begin
                    plen = $urandom_range(1, TAG_LEN - 1);
                    for (int k = 0; k < plen; k++) bytes_q.push_back(TAG_TEXT[k]);
                end
                bad_at = -1;
                if ($urandom_range(5) == 0) bad_at = $urandom_range(TAG_LEN - 1);
                for (int k = 0; k < TAG_LEN; k++)
                    bytes_q.push_back((k == bad_at) ? pick_byte() : TAG_TEXT[k]);
                repeat (SKIP_BYTES_DEF + 2 * WORD_BYTES_DEF) bytes_q.push_back(pick_byte());
            end
            repeat ($urandom_range(4)) bytes_q.push_back(pick_byte());
            // A file cut short at a random byte, which may end it inside a tag, a skip or a word.
            if (style <= 2 && bytes_q.size() > 1) begin
                cut_len = $urandom_range(1, bytes_q.size() - 1);
                while (bytes_q.size() > cut_len) void'(bytes_q.pop_back());
            end
        end
        if (bytes_q.size() == 0) bytes_q.push_back(pick_byte());
        foreach (bytes_q[k])
            send_byte(bytes_q[k], k == bytes_q.size() - 1, WANT_PREDICT);
        file_count++;
    endtask

    // Result receiver; a long hold-off is counted here when requested.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_len > 0) begin
                out_ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
            end else begin
                out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        t_out_item want_item;
        if (rst_n && out_valid && out_ready) begin
            if (due_results.size() == 0) begin
                report_mismatch("transaction with nothing expected", 64'(out_data.kind), '0);
            end else begin
                want_item = due_results.pop_front();
                if (out_data.kind !== want_item.kind)
                    report_mismatch("kind", 64'(out_data.kind), 64'(want_item.kind));
                if (out_data.position_bits !== want_item.position_bits)
                    report_mismatch("position_bits", out_data.position_bits,
                                    want_item.position_bits);
                if (out_data.beat_bits !== want_item.beat_bits)
                    report_mismatch("beat_bits", out_data.beat_bits, want_item.beat_bits);
                if (out_data.record_index !== want_item.record_index)
                    report_mismatch("record_index", 64'(out_data.record_index),
                                    64'(want_item.record_index));
                if (out_data.last_result !== want_item.last_result)
                    report_mismatch("last_result", 64'(out_data.last_result),
                                    64'(want_item.last_result));
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCH_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", WATCH_LIMIT);
            $display("TB_ERROR");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        int         phase_no;
        int         phase_start;
        int         files_in_phase;
        int         mode;
        logic [1:0] skip_sel;
        logic [1:0] limit_sel;

        cur_skip_count   = SKIP_COUNT_RESET;
        cur_record_limit = RECORD_LIMIT_RESET;
        clear_scan();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].op == ROW_CFG)
                write_reg(dir_rows[r].reg_index, dir_rows[r].reg_value);
            else
                send_byte(dir_rows[r].data, dir_rows[r].eos, dir_rows[r].want);
        end

        phase_no = 0;
        while (byte_count < ITEM_TARGET) begin
            if (phase_no < 8) begin
                skip_sel  = SKIP_PLAN[phase_no];
                limit_sel = LIMIT_PLAN[phase_no];
            end else begin
                skip_sel  = 2'($urandom);
                limit_sel = 2'($urandom_range(1, 3));
            end
            write_reg(CFG_SKIP_COUNT, skip_sel);
            write_reg(CFG_RECORD_LIMIT, limit_sel);
            mode         = phase_no % 4;
            tx_idle_pct  = (mode == 1) ? 76 : (mode == 3) ? 6 : 0;
            rx_stall_pct = (mode == 2) ? 76 : (mode == 3) ? 6 : 0;
            if (phase_no == 5) begin
                // Each one-byte file yields a status, so input stalls on the queue during the hold.
                hold_len = HOLD_CYCLES;
                repeat (12) send_byte(pick_byte(), 1'b1, WANT_PREDICT);
            end
            phase_start    = byte_count;
            files_in_phase = 0;
            while (byte_count - phase_start < PHASE_ITEMS && files_in_phase < PHASE_FILES
                   && byte_count < ITEM_TARGET) begin
                send_file();
                files_in_phase++;
            end
            phase_no++;
        end

        in_valid <= 1'b0;
        while (due_results.size() > 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Streamed %0d bytes in %0d files: directed rows, then %0d random phases (%0d writes).",
                 byte_count, file_count, phase_no, cfg_writes);
        $display("Checked %0d records and %0d end-of-file reports, %0d mismatches.",
                 record_count, status_count, err_count);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
